// ----- hw/rtl/jtok_pkg.sv -----
// ----------------------------------------------------------------------------
// jtok_pkg
// Shared types and constants for the character tokenizer: token kinds,
// character codes, byte classification and the result record.
// ----------------------------------------------------------------------------
package jtok_pkg;

   localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
   localparam logic [3:0] KIND_STRING   = 4'd1;
   localparam logic [3:0] KIND_WORD     = 4'd2;
   localparam logic [3:0] KIND_DIGITS   = 4'd3;
   localparam logic [3:0] KIND_DOT      = 4'd4;
   localparam logic [3:0] KIND_COLON    = 4'd5;
   localparam logic [3:0] KIND_SEMI     = 4'd6;
   localparam logic [3:0] KIND_COMMA    = 4'd7;
   localparam logic [3:0] KIND_LBRACE   = 4'd8;
   localparam logic [3:0] KIND_RBRACE   = 4'd9;
   localparam logic [3:0] KIND_LBRACKET = 4'd10;
   localparam logic [3:0] KIND_RBRACKET = 4'd11;
   localparam logic [3:0] KIND_SYMBOL   = 4'd12;
   localparam logic [3:0] KIND_EOF      = 4'd13;

   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_COLON      = 8'h3A;
   localparam logic [7:0] CHAR_SEMI       = 8'h3B;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET   = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET   = 8'h5D;

   typedef struct packed {
      logic       is_space;
      logic       is_digit;
      logic       is_word_start;
      logic       is_punct;
      logic       is_quote;
      logic       is_backslash;
      logic       is_newline;
      logic [3:0] single_kind;
   } char_class_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic        token_start;
      logic        has_text;
      logic [7:0]  text_byte_out;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic        unterminated_string;
   } token_type;

endpackage

// ----- hw/rtl/json_style_char_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// json_style_char_tokenizer_core
// Streaming tokenizer for JSON-like text, one byte or end mark per request.
// A result is registered in the result buffer before it is offered on the response channel.
// Throughput: one request per cycle while the result buffer has space.
// A two-entry result buffer keeps requests flowing while a result waits.
// Reset (synchronous) sets the mode to idle, clears line/column and empties
// the result buffer.
// ----------------------------------------------------------------------------
module json_style_char_tokenizer_core
   import jtok_pkg::*;
#(
   parameter int POSITION_WIDTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte_in,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic        rsp_token_start,
   output logic        rsp_has_text,
   output logic [7:0]  rsp_text_byte_out,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic        rsp_unterminated_string
);

   logic      accept;
   logic      produce;
   logic      space;
   token_type result;
   token_type rsp_data;

   assign req_ready = space;
   assign accept    = req_valid && space;

   jtok_lexer #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .text_byte_in (req_text_byte_in),
      .end_of_input (req_end_of_input),
      .produce      (produce),
      .result       (result)
   );

   jtok_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && produce),
      .push_data (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_token_kind          = rsp_data.token_kind;
   assign rsp_token_start         = rsp_data.token_start;
   assign rsp_has_text            = rsp_data.has_text;
   assign rsp_text_byte_out       = rsp_data.text_byte_out;
   assign rsp_start_line          = rsp_data.start_line;
   assign rsp_start_column        = rsp_data.start_column;
   assign rsp_unterminated_string = rsp_data.unterminated_string;

endmodule

// ----- hw/rtl/jtok_classify.sv -----
// ----------------------------------------------------------------------------
// jtok_classify
// Byte classification: whitespace, digit, word start, punctuation and the
// single-character punctuation token kinds.
// ----------------------------------------------------------------------------
module jtok_classify
   import jtok_pkg::*;
(
   input  logic [7:0]     byte_in,
   output char_class_type char_class
);

   logic is_alpha;

   always_comb begin
      is_alpha                 = (byte_in inside {[8'h41:8'h5A], [8'h61:8'h7A]});
      char_class.is_space      = (byte_in inside {8'h20, [8'h09:8'h0D]});
      char_class.is_digit      = (byte_in inside {[8'h30:8'h39]});
      char_class.is_word_start = is_alpha || (byte_in == CHAR_UNDERSCORE);
      char_class.is_punct      = (byte_in inside {[8'h21:8'h7E]}) && !is_alpha
                                 && !char_class.is_digit;
      char_class.is_quote      = (byte_in == CHAR_QUOTE);
      char_class.is_backslash  = (byte_in == CHAR_BACKSLASH);
      char_class.is_newline    = (byte_in == CHAR_NEWLINE);
      case (byte_in)
         CHAR_DOT:      char_class.single_kind = KIND_DOT;
         CHAR_COLON:    char_class.single_kind = KIND_COLON;
         CHAR_SEMI:     char_class.single_kind = KIND_SEMI;
         CHAR_COMMA:    char_class.single_kind = KIND_COMMA;
         CHAR_LBRACE:   char_class.single_kind = KIND_LBRACE;
         CHAR_RBRACE:   char_class.single_kind = KIND_RBRACE;
         CHAR_LBRACKET: char_class.single_kind = KIND_LBRACKET;
         CHAR_RBRACKET: char_class.single_kind = KIND_RBRACKET;
         default:       char_class.single_kind = KIND_UNKNOWN;
      endcase
   end

endmodule

// ----- hw/rtl/jtok_lexer.sv -----
// ----------------------------------------------------------------------------
// jtok_lexer
// Lexer mode and line/column position registers with the next-state and
// result logic for one request.
// ----------------------------------------------------------------------------
module jtok_lexer
   import jtok_pkg::*;
#(
   parameter int POSITION_WIDTH = 16
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic [7:0] text_byte_in,
   input  logic      end_of_input,
   output logic      produce,
   output token_type result
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_STR  = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_DIG  = 3'd3,
      MODE_WORD = 3'd4,
      MODE_UNK  = 3'd5
   } mode_type;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   mode_type                  mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] line_ff, line_in;
   logic [POSITION_WIDTH-1:0] column_ff, column_in;
   char_class_type            cls;
   logic                      idle_handle;
   logic [15:0]               line_sat, column_sat;

   function automatic logic [15:0] sat16(input logic [POSITION_WIDTH-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      sat16 = (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
   endfunction

   jtok_classify u_classify (
      .byte_in    (text_byte_in),
      .char_class (cls)
   );

   always_comb begin
      line_sat    = sat16(line_ff);
      column_sat  = sat16(column_ff);
      produce     = 1'b0;
      result      = '0;
      mode_in     = mode_ff;
      line_in     = line_ff;
      column_in   = column_ff;
      idle_handle = 1'b0;

      if (end_of_input) begin
         produce                    = 1'b1;
         result.token_kind          = KIND_EOF;
         result.token_start         = 1'b1;
         result.start_line          = line_sat;
         result.start_column        = column_sat;
         result.unterminated_string = (mode_ff == MODE_STR) || (mode_ff == MODE_ESC);
         mode_in                    = MODE_IDLE;
         line_in                    = '0;
         column_in                  = '0;
      end else begin
         case (mode_ff)
            MODE_STR: begin
               if (cls.is_backslash) begin
                  mode_in = MODE_ESC;
               end else if (cls.is_quote) begin
                  mode_in = MODE_IDLE;
               end else begin
                  produce              = 1'b1;
                  result.token_kind    = KIND_STRING;
                  result.has_text      = 1'b1;
                  result.text_byte_out = text_byte_in;
               end
            end
            MODE_ESC: begin
               produce              = 1'b1;
               result.token_kind    = KIND_STRING;
               result.has_text      = 1'b1;
               result.text_byte_out = text_byte_in;
               mode_in              = MODE_STR;
            end
            MODE_DIG: begin
               if (cls.is_digit) begin
                  produce              = 1'b1;
                  result.token_kind    = KIND_DIGITS;
                  result.has_text      = 1'b1;
                  result.text_byte_out = text_byte_in;
               end else begin
                  mode_in     = MODE_IDLE;
                  idle_handle = 1'b1;
               end
            end
            MODE_WORD, MODE_UNK: begin
               if (cls.is_space) begin
                  mode_in = MODE_IDLE;
               end else begin
                  produce              = 1'b1;
                  result.token_kind    = (mode_ff == MODE_WORD) ? KIND_WORD : KIND_UNKNOWN;
                  result.has_text      = 1'b1;
                  result.text_byte_out = text_byte_in;
               end
            end
            default: begin
               mode_in     = MODE_IDLE;
               idle_handle = 1'b1;
            end
         endcase

         // first byte of a new token
         if (idle_handle && !cls.is_space) begin
            produce              = 1'b1;
            result.token_start   = 1'b1;
            result.has_text      = 1'b1;
            result.text_byte_out = text_byte_in;
            result.start_line    = line_sat;
            result.start_column  = column_sat;
            if (cls.is_quote) begin
               result.token_kind    = KIND_STRING;
               result.has_text      = 1'b0;
               result.text_byte_out = '0;
               mode_in              = MODE_STR;
            end else if (cls.single_kind != KIND_UNKNOWN) begin
               result.token_kind = cls.single_kind;
            end else if (cls.is_digit) begin
               result.token_kind = KIND_DIGITS;
               mode_in           = MODE_DIG;
            end else if (cls.is_word_start) begin
               result.token_kind = KIND_WORD;
               mode_in           = MODE_WORD;
            end else if (cls.is_punct) begin
               result.token_kind = KIND_SYMBOL;
            end else begin
               result.token_kind = KIND_UNKNOWN;
               mode_in           = MODE_UNK;
            end
         end

         if (cls.is_newline) begin
            if (line_ff != POS_MAX) begin
               line_in = line_ff + POSITION_WIDTH'(1);
            end
            column_in = '0;
         end else if (column_ff != POS_MAX) begin
            column_in = column_ff + POSITION_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= '0;
         column_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         column_ff <= column_in;
      end
   end

endmodule

// ----- hw/rtl/jtok_rsp_buffer.sv -----
// ----------------------------------------------------------------------------
// jtok_rsp_buffer
// Result register with a skid stage, so a new request is taken while a
// finished result waits on the response channel.
// ----------------------------------------------------------------------------
module jtok_rsp_buffer
   import jtok_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_data,
   output logic      space,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output token_type rsp_data
);

   logic      main_valid_ff, main_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   token_type main_ff, main_in;
   token_type skid_ff, skid_in;
   logic      pop;

   always_comb begin
      pop           = main_valid_ff && rsp_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming JSON-style character tokenizer.
// A queue of source bytes and end marks feeds a clocked driver. A clocked
// monitor runs a cycle-free tokenizer model on every accepted request and
// checks each result, field by field, against the oldest predicted token.
// Stimulus is a short directed lead-in, random token-shaped text with noise,
// a long receiver hold-off, a drain pause, a restart after an end mark,
// and a final stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;
   import jtok_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam logic [15:0] POS_MAX = 16'hFFFF;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      LEX_IDLE, LEX_STRING, LEX_ESCAPE, LEX_DIGITS, LEX_WORD, LEX_UNKNOWN
   } lex_mode_type;

   typedef struct {
      logic [7:0] text;
      logic       eoi;
      bit         drain_first;
      bit         stall_rx;
      bit         quiet;
   } source_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte_in = '0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic        rsp_token_start;
   logic        rsp_has_text;
   logic [7:0]  rsp_text_byte_out;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic        rsp_unterminated_string;

   source_req_type bytes_to_send[$];
   source_req_type cur_req = '{default: 0};
   token_type      tokens_due[$];

   lex_mode_type lex_mode = LEX_IDLE;
   logic [15:0]  cur_line = '0;
   logic [15:0]  cur_col = '0;

   bit next_drain = 0;
   bit next_stall = 0;
   bit quiet_fill = 0;
   bit req_taken = 0;
   bit rx_hold_go = 0;
   bit rx_quiet = 0;
   int gap_left = 0;
   int rx_hold_left = 0;
   int rx_stall_left = 0;

   int cycles = 0;
   int failures = 0;
   int requests_taken = 0;
   int end_marks = 0;
   int results_seen = 0;
   int tokens_started = 0;
   int open_strings = 0;

   json_style_char_tokenizer_core u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_text_byte_in        (req_text_byte_in),
      .req_end_of_input        (req_end_of_input),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_token_kind          (rsp_token_kind),
      .rsp_token_start         (rsp_token_start),
      .rsp_has_text            (rsp_has_text),
      .rsp_text_byte_out       (rsp_text_byte_out),
      .rsp_start_line          (rsp_start_line),
      .rsp_start_column        (rsp_start_column),
      .rsp_unterminated_string (rsp_unterminated_string)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit class_space(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic bit class_digit(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic bit class_alpha(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] b);
      case (b)
         CHAR_DOT:      return KIND_DOT;
         CHAR_COLON:    return KIND_COLON;
         CHAR_SEMI:     return KIND_SEMI;
         CHAR_COMMA:    return KIND_COMMA;
         CHAR_LBRACE:   return KIND_LBRACE;
         CHAR_RBRACE:   return KIND_RBRACE;
         CHAR_LBRACKET: return KIND_LBRACKET;
         CHAR_RBRACKET: return KIND_RBRACKET;
         default:       return KIND_UNKNOWN;
      endcase
   endfunction

   // advances the tokenizer model by one request; returns 1 when a token result is due
   function automatic bit tokenize_byte(input logic [7:0] b, input logic eoi,
                                        output token_type tok);
      bit emit;
      bit fresh;
      logic [3:0] k;
      tok = '0;
      emit = 0;
      fresh = 0;
      if (eoi) begin
         tok.token_kind = KIND_EOF;
         tok.token_start = 1'b1;
         tok.start_line = cur_line;
         tok.start_column = cur_col;
         tok.unterminated_string = (lex_mode == LEX_STRING || lex_mode == LEX_ESCAPE);
         lex_mode = LEX_IDLE;
         cur_line = '0;
         cur_col = '0;
         return 1;
      end
      case (lex_mode)
         LEX_STRING: begin
            if (b == CHAR_BACKSLASH) lex_mode = LEX_ESCAPE;
            else if (b == CHAR_QUOTE) lex_mode = LEX_IDLE;
            else begin
               emit = 1;
               tok.token_kind = KIND_STRING;
            end
         end
         LEX_ESCAPE: begin
            emit = 1;
            tok.token_kind = KIND_STRING;
            lex_mode = LEX_STRING;
         end
         LEX_DIGITS: begin
            if (class_digit(b)) begin
               emit = 1;
               tok.token_kind = KIND_DIGITS;
            end else begin
               lex_mode = LEX_IDLE;
               fresh = 1;
            end
         end
         LEX_WORD, LEX_UNKNOWN: begin
            if (class_space(b)) lex_mode = LEX_IDLE;
            else begin
               emit = 1;
               tok.token_kind = (lex_mode == LEX_WORD) ? KIND_WORD : KIND_UNKNOWN;
            end
         end
         default: begin
            lex_mode = LEX_IDLE;
            fresh = 1;
         end
      endcase
      if (emit) begin
         tok.has_text = 1'b1;
         tok.text_byte_out = b;
      end
      if (fresh && !class_space(b)) begin
         emit = 1;
         k = punct_kind(b);
         tok.token_start = 1'b1;
         tok.start_line = cur_line;
         tok.start_column = cur_col;
         tok.has_text = 1'b1;
         tok.text_byte_out = b;
         if (b == CHAR_QUOTE) begin
            tok.token_kind = KIND_STRING;
            tok.has_text = 1'b0;
            tok.text_byte_out = '0;
            lex_mode = LEX_STRING;
         end else if (k != KIND_UNKNOWN) begin
            tok.token_kind = k;
         end else if (class_digit(b)) begin
            tok.token_kind = KIND_DIGITS;
            lex_mode = LEX_DIGITS;
         end else if (class_alpha(b) || b == CHAR_UNDERSCORE) begin
            tok.token_kind = KIND_WORD;
            lex_mode = LEX_WORD;
         end else if (b >= CHAR_BANG && b <= CHAR_TILDE) begin
            tok.token_kind = KIND_SYMBOL;
         end else begin
            tok.token_kind = KIND_UNKNOWN;
            lex_mode = LEX_UNKNOWN;
         end
      end
      if (b == CHAR_NEWLINE) begin
         if (cur_line != POS_MAX) cur_line++;
         cur_col = '0;
      end else if (cur_col != POS_MAX) begin
         cur_col++;
      end
      return emit;
   endfunction

   task automatic compare_token(input token_type got, input token_type want);
      if (got.token_kind !== want.token_kind) begin
         $error("token_kind expected %0d got %0d", want.token_kind, got.token_kind);
         failures++;
      end
      if (got.token_start !== want.token_start) begin
         $error("token_start expected %0d got %0d", want.token_start, got.token_start);
         failures++;
      end
      if (got.has_text !== want.has_text) begin
         $error("has_text expected %0d got %0d", want.has_text, got.has_text);
         failures++;
      end
      if (got.text_byte_out !== want.text_byte_out) begin
         $error("text_byte_out expected %h got %h", want.text_byte_out, got.text_byte_out);
         failures++;
      end
      if (got.start_line !== want.start_line) begin
         $error("start_line expected %0d got %0d", want.start_line, got.start_line);
         failures++;
      end
      if (got.start_column !== want.start_column) begin
         $error("start_column expected %0d got %0d", want.start_column, got.start_column);
         failures++;
      end
      if (got.unterminated_string !== want.unterminated_string) begin
         $error("unterminated_string expected %0d got %0d",
                want.unterminated_string, got.unterminated_string);
         failures++;
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input logic eoi);
      source_req_type r;
      r.text = b;
      r.eoi = eoi;
      r.drain_first = next_drain;
      r.stall_rx = next_stall;
      r.quiet = quiet_fill;
      bytes_to_send.push_back(r);
      next_drain = 0;
      next_stall = 0;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 1) != 0) return 8'h41 + 8'($urandom_range(0, 25));
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   // one token-shaped piece of source text, or whitespace, an end mark or noise
   task automatic add_fragment();
      int pick;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         add_byte(CHAR_QUOTE, 1'b0);
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
               0: begin
                  add_byte(CHAR_BACKSLASH, 1'b0);
                  add_byte(8'($urandom_range(0, 255)), 1'b0);
               end
               1: add_byte(CHAR_NEWLINE, 1'b0);
               2: add_byte(8'($urandom_range(0, 255)), 1'b0);
               default: add_byte(8'($urandom_range(CHAR_SPACE, CHAR_TILDE)), 1'b0);
            endcase
         end
         if ($urandom_range(0, 11) != 0) add_byte(CHAR_QUOTE, 1'b0);
      end else if (pick < 36) begin
         repeat ($urandom_range(1, 6))
            add_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
      end else if (pick < 50) begin
         add_byte(($urandom_range(0, 5) == 0) ? CHAR_UNDERSCORE : pick_letter(), 1'b0);
         repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
               0: add_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
               1: add_byte(CHAR_UNDERSCORE, 1'b0);
               2: add_byte(8'($urandom_range(CHAR_BANG, CHAR_TILDE)), 1'b0);
               default: add_byte(pick_letter(), 1'b0);
            endcase
         end
      end else if (pick < 66) begin
         case ($urandom_range(0, 9))
            0: add_byte(CHAR_DOT, 1'b0);
            1: add_byte(CHAR_COLON, 1'b0);
            2: add_byte(CHAR_SEMI, 1'b0);
            3: add_byte(CHAR_COMMA, 1'b0);
            4: add_byte(CHAR_LBRACE, 1'b0);
            5: add_byte(CHAR_RBRACE, 1'b0);
            6: add_byte(CHAR_LBRACKET, 1'b0);
            7: add_byte(CHAR_RBRACKET, 1'b0);
            default: add_byte(8'($urandom_range(CHAR_BANG, CHAR_TILDE)), 1'b0);
         endcase
      end else if (pick < 84) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0: add_byte(CHAR_SPACE, 1'b0);
               1: add_byte(CHAR_NEWLINE, 1'b0);
               2: add_byte(CHAR_TAB, 1'b0);
               default: add_byte(8'($urandom_range(CHAR_TAB, CHAR_CR)), 1'b0);
            endcase
         end
      end else if (pick < 88) begin
         do b = 8'($urandom_range(0, 255));
         while (class_space(b) || (b >= CHAR_BANG && b <= CHAR_TILDE));
         add_byte(b, 1'b0);
         repeat ($urandom_range(0, 3)) begin
            do b = 8'($urandom_range(0, 255));
            while (class_space(b));
            add_byte(b, 1'b0);
         end
      end else if (pick < 91) begin
         add_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      source_req_type nxt;
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_taken && !cur_req.quiet && $urandom_range(0, 11) == 0)
            gap_left = $urandom_range(1, 13);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bytes_to_send.size() > 0 &&
                      !(bytes_to_send[0].drain_first && tokens_due.size() != 0)) begin
            nxt = bytes_to_send.pop_front();
            cur_req = nxt;
            req_text_byte_in <= nxt.text;
            req_end_of_input <= nxt.eoi;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rx_hold_go) begin
            rx_hold_go = 0;
            rx_hold_left = RX_HOLD_CYCLES;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_ready <= 1'b0;
         end else if (!rx_quiet && $urandom_range(0, 11) == 0) begin
            rx_stall_left = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      token_type got;
      token_type want;
      token_type tok;
      cycles++;
      req_taken = 0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.token_kind = rsp_token_kind;
            got.token_start = rsp_token_start;
            got.has_text = rsp_has_text;
            got.text_byte_out = rsp_text_byte_out;
            got.start_line = rsp_start_line;
            got.start_column = rsp_start_column;
            got.unterminated_string = rsp_unterminated_string;
            results_seen++;
            if (tokens_due.size() == 0) begin
               $error("result with no token pending, kind %0d", got.token_kind);
               failures++;
            end else begin
               want = tokens_due.pop_front();
               compare_token(got, want);
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1;
            requests_taken++;
            if (req_end_of_input) end_marks++;
            if (tokenize_byte(req_text_byte_in, req_end_of_input, tok)) begin
               tokens_due.push_back(tok);
               if (tok.token_start) tokens_started++;
               if (tok.unterminated_string) open_strings++;
            end
            if (cur_req.stall_rx) rx_hold_go = 1;
            rx_quiet = cur_req.quiet;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int total_requests;

      // directed lead-in
      add_text("{\"a\\\"b\":[12,3.5]};");
      add_text("_w#x\t@ ");
      add_byte(8'h80, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(CHAR_NEWLINE, 1'b0);
      add_text("\"q\\");
      add_byte(8'hFF, 1'b1);
      add_text("\"z\n");
      add_byte(8'h00, 1'b1);
      add_byte(8'h5A, 1'b1);

      // long receiver hold-off while a long word keeps the sender busy
      next_stall = 1;
      add_byte(pick_letter(), 1'b0);
      repeat (40) add_byte(pick_letter(), 1'b0);
      next_drain = 1;
      add_byte(CHAR_SPACE, 1'b0);

      for (int i = 0; i < 300; i++) begin
         if (i == 150) next_drain = 1;
         add_fragment();
      end

      // restart after an end mark, then an open string at the end
      quiet_fill = 1;
      next_drain = 1;
      add_byte(8'h00, 1'b1);
      add_text("x\n\"");
      add_byte(8'h00, 1'b1);

      // closing stretch, no idling
      for (int i = 0; i < 50; i++) add_fragment();
      add_byte(8'h00, 1'b1);

      total_requests = bytes_to_send.size();
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (requests_taken < total_requests) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d requests (%0d end marks) in %0d cycles, %0d results checked",
               requests_taken, end_marks, cycles, results_seen);
      $display("tb: %0d tokens started, %0d unterminated strings, %0d mismatches",
               tokens_started, open_strings, failures);
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
